// ===== rtl/ssr_pkg.sv =====
// Shared types, constants and the segment table for the seven-segment text raster.
// No dependencies; imported by every module of the block.
`default_nettype none
package ssr_pkg;

    // Sizing
    localparam int MAX_SCALE  = 15;
    localparam int MAX_DIGITS = 8;

    localparam int SCALE_W   = 4;   // scale register field
    localparam int VALUE_W   = 27;  // number_value register field
    localparam int CFG_W     = 27;  // widest register
    localparam int CFG_IDX_W = 1;

    localparam int ESCALE_W  = $clog2(MAX_SCALE + 1);
    localparam int ROW_W     = $clog2(2 * MAX_SCALE + 4);
    localparam int COL_W     = $clog2(MAX_SCALE + 4);
    localparam int SLOT_W    = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for v < 2^32
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;
    localparam int          PROD_W        = VALUE_W + 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER = 1'b1;

    // Output character codes
    typedef enum logic [1:0] {
        CH_SPACE   = 2'd0,
        CH_DASH    = 2'd1,
        CH_BAR     = 2'd2,
        CH_NEWLINE = 2'd3
    } char_code_t;

    // Segment bit positions
    localparam int SEG_TOP = 0;
    localparam int SEG_UL  = 1;
    localparam int SEG_UR  = 2;
    localparam int SEG_MID = 3;
    localparam int SEG_LL  = 4;
    localparam int SEG_LR  = 5;
    localparam int SEG_BOT = 6;

    typedef logic [MAX_DIGITS-1:0][3:0] digit_vec_t;

    // Converted number as seen by the raster scan
    typedef struct packed {
        digit_vec_t              digits;      // index = display slot
        logic [SLOT_W-1:0]       first_slot;  // first shown slot
    } ssr_digits_t;

    function automatic logic [6:0] seg_mask(input logic [3:0] digit);
        logic [6:0] m;
        case (digit)
            4'd0:    m = 7'h77;
            4'd1:    m = 7'h24;
            4'd2:    m = 7'h5D;
            4'd3:    m = 7'h6D;
            4'd4:    m = 7'h2E;
            4'd5:    m = 7'h6B;
            4'd6:    m = 7'h7B;
            4'd7:    m = 7'h25;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ssr_digit_conv.sv =====
// Decimal digit extraction for number_value, one digit per cycle by reciprocal multiply.
// Depends on ssr_pkg.
`default_nettype none
module ssr_digit_conv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [ssr_pkg::VALUE_W-1:0]   value,
    output logic                               busy,
    output ssr_pkg::ssr_digits_t               conv
);
    import ssr_pkg::*;

    logic                     busy_reg;
    logic [VALUE_W-1:0]       cur_reg;
    logic [DIDX_W-1:0]        slot_reg;
    digit_vec_t               digits_reg;
    logic [SLOT_W-1:0]        first_reg;

    logic [PROD_W-1:0]        prod;
    logic [VALUE_W-1:0]       quot;
    logic [VALUE_W-1:0]       quot10;
    logic [3:0]               rem;

    // One divide-by-ten step on the running quotient
    always_comb
    begin
        prod   = PROD_W'(cur_reg) * PROD_W'(RECIP10);
        quot   = VALUE_W'(prod >> RECIP10_SHIFT);
        quot10 = (quot << 3) + (quot << 1);
        rem    = 4'(cur_reg - quot10);
    end

    // Sweep from the last slot (MAX_DIGITS - 1) down to slot zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            slot_reg   <= DIDX_W'(MAX_DIGITS - 1);
            digits_reg <= '0;
            first_reg  <= SLOT_W'(MAX_DIGITS - 1);
            cur_reg    <= '0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            cur_reg   <= value;
            slot_reg  <= DIDX_W'(MAX_DIGITS - 1);
            first_reg <= SLOT_W'(MAX_DIGITS - 1);
        end
        else if (busy_reg)
        begin
            digits_reg[slot_reg] <= rem;
            // lower slots override, so the last nonzero hit is the first shown slot
            if (cur_reg != '0 && SLOT_W'(slot_reg) < SLOT_W'(MAX_DIGITS - 1))
            begin
                first_reg <= SLOT_W'(slot_reg);
            end
            cur_reg <= quot;
            if (slot_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                slot_reg <= slot_reg - 1'b1;
            end
        end
    end

    assign busy            = busy_reg;
    assign conv.digits     = digits_reg;
    assign conv.first_slot = first_reg;

endmodule
`default_nettype wire

// ===== rtl/ssr_raster.sv =====
// Raster scan counters, character decode and the output register.
// Depends on ssr_pkg.
`default_nettype none
module ssr_raster (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          restart,
    input  wire logic [ssr_pkg::SCALE_W-1:0]   scale,
    input  wire ssr_pkg::ssr_digits_t          conv,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output ssr_pkg::char_code_t                char_code,
    output logic                               last_of_frame
);
    import ssr_pkg::*;

    logic [ROW_W-1:0]   row_reg,  row_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [COL_W-1:0]   col_reg,  col_next;
    logic               out_valid_reg;
    char_code_t         char_reg, char_next;
    logic               last_reg, last_next;

    logic [ESCALE_W-1:0] s;
    logic [ROW_W-1:0]    rows;
    logic [COL_W-1:0]    cell_len;
    logic [ROW_W-1:0]    r;
    logic [SLOT_W-1:0]   d;
    logic [COL_W-1:0]    c;
    logic [SLOT_W-1:0]   f;
    logic [3:0]          digit;
    logic [6:0]          m;
    logic                upper;

    // Effective scale, saturated to the meaningful range
    always_comb
    begin
        if (scale == '0)
        begin
            s = ESCALE_W'(1);
        end
        else if (32'(scale) > MAX_SCALE)
        begin
            s = ESCALE_W'(MAX_SCALE);
        end
        else
        begin
            s = ESCALE_W'(scale);
        end
    end

    // Bring the position into range, emit one character, advance
    always_comb
    begin
        rows      = (ROW_W'(s) << 1) + ROW_W'(3);
        cell_len  = COL_W'(s) + COL_W'(3);
        f         = conv.first_slot;
        r         = row_reg;
        d         = slot_reg;
        c         = col_reg;
        char_next = CH_SPACE;
        last_next = 1'b0;

        if (restart || r >= rows)
        begin
            r = '0;
            d = f;
            c = '0;
        end
        if (d < f)
        begin
            d = f;
            c = '0;
        end
        if (d > SLOT_W'(MAX_DIGITS))
        begin
            d = SLOT_W'(MAX_DIGITS);
        end
        if (d < SLOT_W'(MAX_DIGITS) && c >= cell_len)
        begin
            c = '0;
            d = d + 1'b1;
        end

        digit = conv.digits[d[DIDX_W-1:0]];
        m     = seg_mask(digit);
        upper = (r < ROW_W'(s) + ROW_W'(1));

        row_next  = r;
        slot_next = d;
        col_next  = c;

        if (d >= SLOT_W'(MAX_DIGITS))
        begin
            // end of row
            char_next = CH_NEWLINE;
            last_next = (r == rows - ROW_W'(1));
            row_next  = r + ROW_W'(1);
            if (row_next >= rows)
            begin
                row_next = '0;
            end
            slot_next = f;
            col_next  = '0;
        end
        else
        begin
            if (r == '0)
            begin
                if (c >= COL_W'(1) && c <= COL_W'(s) && m[SEG_TOP])
                begin
                    char_next = CH_DASH;
                end
            end
            else if (r == ROW_W'(s) + ROW_W'(1))
            begin
                if (c >= COL_W'(1) && c <= COL_W'(s) && m[SEG_MID])
                begin
                    char_next = CH_DASH;
                end
            end
            else if (r == rows - ROW_W'(1))
            begin
                if (c >= COL_W'(1) && c <= COL_W'(s) && m[SEG_BOT])
                begin
                    char_next = CH_DASH;
                end
            end
            else
            begin
                if (c == '0 && (upper ? m[SEG_UL] : m[SEG_LL]))
                begin
                    char_next = CH_BAR;
                end
                if (c == COL_W'(s) + COL_W'(1) && (upper ? m[SEG_UR] : m[SEG_LR]))
                begin
                    char_next = CH_BAR;
                end
            end
            col_next = c + COL_W'(1);
            if (col_next >= cell_len)
            begin
                col_next  = '0;
                slot_next = d + 1'b1;
            end
        end
    end

    // Position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            slot_reg <= SLOT_W'(MAX_DIGITS - 1);
            col_reg  <= '0;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            slot_reg <= slot_next;
            col_reg  <= col_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign char_code     = char_reg;
    assign last_of_frame = last_reg;

endmodule
`default_nettype wire

// ===== rtl/scaled_seven_segment_text_raster_top.sv =====
// Each accepted request's character is registered in the output register; one per cycle.
// Throughput: one character per clock while out_ready is high and no register write or digit
// conversion is under way; the output register frees itself in the same cycle it is taken.
// A write to number_value starts a digit conversion (one divide-by-ten step per
// cycle, MAX_DIGITS steps) during which in_ready is low. Reset (rst_n, async) sets scale 1,
// value 0, and the scan to the top-left of the frame.
`default_nettype none
module scaled_seven_segment_text_raster_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssr_pkg::CFG_W-1:0]      cfg_data,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           restart,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          char_code,
    output logic                                last_of_frame
);
    import ssr_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic               conv_busy;
    logic               conv_load;
    logic               accept;
    ssr_digits_t        conv;
    char_code_t         char_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(1);
        end
        else if (cfg_we && cfg_index == REG_SCALE)
        begin
            scale_reg <= cfg_data[SCALE_W-1:0];
        end
    end

    assign conv_load = cfg_we && (cfg_index == REG_NUMBER);

    ssr_digit_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .value (cfg_data[VALUE_W-1:0]),
        .busy  (conv_busy),
        .conv  (conv)
    );

    // Take a request when no conversion or register write is under way and the result slot is free or being drained
    assign in_ready = !conv_busy && !cfg_we && (!out_valid || out_ready);
    assign accept   = in_valid && in_ready;

    ssr_raster u_raster (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .restart       (restart),
        .scale         (scale_reg),
        .conv          (conv),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .char_code     (char_out),
        .last_of_frame (last_of_frame)
    );

    assign char_code = char_out;

endmodule
`default_nettype wire

// ===== rtl/ssr_checker.sv =====
// Port-level checks for the seven-segment text raster, bound to the top level.
// Depends on ssr_pkg.
`default_nettype none
module ssr_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic                           restart,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [1:0]                     char_code,
    input  wire logic                           last_of_frame
);
    import ssr_pkg::*;

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_of_frame))
        else $error("result changed while stalled");

    // Every accepted request yields a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request gave no result");

    // A frame starts with a blank corner
    a_restart_space: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> char_code == CH_SPACE)
        else $error("new frame did not start with a space");

    // Frame end marker only on a newline
    a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> char_code == CH_NEWLINE)
        else $error("frame end flagged on a non-newline");

    // Number write stalls requests while digits are converted
    a_conv_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_NUMBER |=> !in_ready)
        else $error("request taken during digit conversion");

endmodule

bind scaled_seven_segment_text_raster_top ssr_checker u_ssr_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for scaled_seven_segment_text_raster_top: predicts every character of the raster
// scan and checks each result against it, under random idling on both channels.
// Depends on rtl/ssr_pkg.sv and rtl/scaled_seven_segment_text_raster_top.sv.
module tb_top;
    import ssr_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
    localparam int ITEM_TARGET = 1700;

    // lit segments per decimal digit, index = digit
    localparam logic [9:0][6:0] LIT_SEGS = {
        7'h6F, 7'h7F, 7'h25, 7'h7B, 7'h6B, 7'h2E, 7'h6D, 7'h5D, 7'h24, 7'h77
    };

    typedef struct packed {
        char_code_t code;
        logic       last;
    } char_exp_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 restart;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           char_code;
    logic                 last_of_frame;

    // shadow registers and scan position
    logic [SCALE_W-1:0] shadow_scale;
    logic [VALUE_W-1:0] shadow_value;
    int                 shown_digit [MAX_DIGITS];
    int                 lead_slot;
    int                 scan_row;
    int                 scan_slot;
    int                 scan_col;

    char_exp_t pending_chars [$];
    char_exp_t want;
    int        items_sent;
    int        mismatch_count;
    int        quiet_cycles;
    bit        steady;            // no idling on either side while set

    scaled_seven_segment_text_raster_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_code     (char_code),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return SCALE_W'($urandom_range(1, 2));
        else if (r < 70)
            return SCALE_W'($urandom_range(3, 4));
        else if (r < 80)
            return '0;
        else if (r < 88)
            return SCALE_W'(MAX_SCALE);
        return SCALE_W'($urandom_range(5, 14));
    endfunction

    function automatic int unsigned pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 9);
        else if (r < 50)
            return $urandom_range(0, 99);
        else if (r < 65)
            return $urandom_range(0, 9999);
        else if (r < 75)
            return 0;
        else if (r < 82)
            return 99999999;
        else if (r < 88)
            return $urandom_range(100000000, 134217727);
        return $urandom_range(0, 99999999);
    endfunction

    // split the shadow value into display slots; slot 0 is the most significant
    function automatic void load_digits();
        int unsigned v;
        int unsigned above [MAX_DIGITS];
        v = shadow_value;
        for (int k = MAX_DIGITS - 1; k >= 0; k--)
        begin
            above[k]       = v;
            shown_digit[k] = v % 10;
            v              = v / 10;
        end
        lead_slot = MAX_DIGITS - 1;
        for (int k = MAX_DIGITS - 2; k >= 0; k--)
            if (above[k] != 0)
                lead_slot = k;
    endfunction

    // expected character for one request; advances the scan position
    function automatic char_exp_t scan_next_char(input logic rs);
        int         s;
        int         rows;
        int         cell_len;
        int         seg;
        int         left;
        logic [6:0] lit;
        char_exp_t  res;
        s = (shadow_scale == 0) ? 1 : int'(shadow_scale);
        if (s > MAX_SCALE)
            s = MAX_SCALE;
        rows     = 2 * s + 3;
        cell_len = s + 3;
        res.code = CH_SPACE;
        res.last = 1'b0;

        // bring the position back into the current frame shape
        if (rs || scan_row >= rows)
        begin
            scan_row  = 0;
            scan_slot = lead_slot;
            scan_col  = 0;
        end
        if (scan_slot < lead_slot)
        begin
            scan_slot = lead_slot;
            scan_col  = 0;
        end
        if (scan_slot > MAX_DIGITS)
            scan_slot = MAX_DIGITS;
        if (scan_slot < MAX_DIGITS && scan_col >= cell_len)
        begin
            scan_col = 0;
            scan_slot++;
        end

        if (scan_slot >= MAX_DIGITS)
        begin
            res.code = CH_NEWLINE;
            res.last = (scan_row == rows - 1);
            scan_row++;
            if (scan_row >= rows)
                scan_row = 0;
            scan_slot = lead_slot;
            scan_col  = 0;
        end
        else
        begin
            lit = LIT_SEGS[shown_digit[scan_slot]];
            if (scan_row == 0 || scan_row == s + 1 || scan_row == 2 * s + 2)
            begin
                seg = (scan_row == 0) ? SEG_TOP : ((scan_row == s + 1) ? SEG_MID : SEG_BOT);
                if (scan_col >= 1 && scan_col <= s && lit[seg])
                    res.code = CH_DASH;
            end
            else
            begin
                left = (scan_row < s + 1) ? SEG_UL : SEG_LL;
                if (scan_col == 0 && lit[left])
                    res.code = CH_BAR;
                if (scan_col == s + 1 && lit[left + 1])
                    res.code = CH_BAR;
            end
            scan_col++;
            if (scan_col >= cell_len)
            begin
                scan_col = 0;
                scan_slot++;
            end
        end
        return res;
    endfunction

    // one request, after a random gap; returns once the design has taken the request
    task automatic send_char_request(input logic rs);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        pending_chars.push_back(scan_next_char(rs));
        items_sent++;
    endtask

    task automatic send_run(input int n);
        repeat (n) send_char_request(1'b0);
    endtask

    // wait for every outstanding character, then a short pause
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SCALE)
            shadow_scale = data[SCALE_W-1:0];
        else
        begin
            shadow_value = data[VALUE_W-1:0];
            load_digits();
        end
        @(posedge clk);
    endtask

    // field extremes, restart, scale zero and maximum, values past eight digits
    task automatic test_directed();
        send_run(6);
        drain_pipe();
        write_register(REG_SCALE, '0);
        send_char_request(1'b1);
        send_run(3);
        drain_pipe();
        write_register(REG_SCALE, '1);
        write_register(REG_NUMBER, CFG_W'(99999999));
        send_char_request(1'b1);
        send_run(4);
        drain_pipe();
        write_register(REG_NUMBER, '1);
        send_char_request(1'b1);
        send_run(4);
        drain_pipe();
        write_register(REG_SCALE, CFG_W'(2));
        write_register(REG_NUMBER, '0);
        send_run(5);
    endtask

    // register changes that leave the scan outside the new frame shape
    task automatic test_config_mid_frame();
        drain_pipe();
        write_register(REG_SCALE, CFG_W'(MAX_SCALE));
        write_register(REG_NUMBER, CFG_W'(7));
        send_char_request(1'b1);
        send_run(19 * 20);
        drain_pipe();
        write_register(REG_SCALE, CFG_W'(2));          // row now past the last one
        send_run(40);
        drain_pipe();
        write_register(REG_SCALE, CFG_W'(1));
        write_register(REG_NUMBER, CFG_W'(12345678));
        send_char_request(1'b1);
        send_run(9);
        drain_pipe();
        write_register(REG_NUMBER, CFG_W'(5));         // slot now ahead of the first shown digit
        send_run(30);
        drain_pipe();
        write_register(REG_SCALE, CFG_W'(MAX_SCALE));
        write_register(REG_NUMBER, CFG_W'(88));
        send_char_request(1'b1);
        send_run(9);
        drain_pipe();
        write_register(REG_SCALE, CFG_W'(1));          // column now past the cell
        send_run(30);
    endtask

    // phases of random settings with mostly continuous scans
    task automatic test_random_frames(input int target);
        int                cfg_mode;
        int                rs_mode;
        int                n;
        logic              rs;
        logic [CFG_W-1:0]  d;
        while (items_sent < target)
        begin
            drain_pipe();
            steady   = ($urandom_range(0, 4) == 0);
            cfg_mode = $urandom_range(0, 9);
            if (cfg_mode <= 7)
            begin
                d = CFG_W'($urandom);
                d[SCALE_W-1:0] = pick_scale();
                write_register(REG_SCALE, d);
            end
            if (cfg_mode <= 6 || cfg_mode == 8)
                write_register(REG_NUMBER, CFG_W'(pick_value()));
            rs_mode = $urandom_range(0, 9);
            n       = $urandom_range(20, 120);
            repeat (n)
            begin
                if (rs_mode <= 6)
                    rs = ($urandom_range(0, 59) == 0);
                else if (rs_mode <= 8)
                    rs = 1'b0;
                else
                    rs = ($urandom_range(0, 2) == 0);
                send_char_request(rs);
            end
        end
        steady = 1'b0;
    endtask

    // result side: random stalls on out_ready
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
        end
    end

    // compare each character with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected result: char_code=%0d last_of_frame=%0d",
                       char_code, last_of_frame);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0d, got %0d", want.code, char_code);
                    mismatch_count++;
                end
                if (last_of_frame !== want.last)
                begin
                    $error("last_of_frame: expected %0d, got %0d", want.last, last_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SCALE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        steady         = 1'b0;
        items_sent     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;

        // reset state of the scan
        shadow_scale = SCALE_W'(1);
        shadow_value = '0;
        load_digits();
        scan_row  = 0;
        scan_slot = MAX_DIGITS - 1;
        scan_col  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_mid_frame();
        test_random_frames(ITEM_TARGET);

        drain_pipe();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ssr_pkg.sv
rtl/ssr_digit_conv.sv
rtl/ssr_raster.sv
rtl/scaled_seven_segment_text_raster_top.sv
rtl/ssr_checker.sv
verif/tb_top.sv
